@@ hdl/rcct_pkg.sv @@
// Package for the routing congestion cost table.
// Holds item and result beat types, function and register codes, reset values.
// No dependencies.
package rcct_pkg;

    localparam int NUM_PORTS_DEF = 1024;

    localparam logic [2:0] FUNC_MARK     = 3'd0;
    localparam logic [2:0] FUNC_COMMIT   = 3'd1;
    localparam logic [2:0] FUNC_UNCOMMIT = 3'd2;
    localparam logic [2:0] FUNC_QUERY    = 3'd3;
    localparam logic [2:0] FUNC_PASS     = 3'd4;

    localparam logic [2:0] REG_PRESENT_FACTOR = 3'd0;
    localparam logic [2:0] REG_INIT_INC       = 3'd1;
    localparam logic [2:0] REG_INC_SCALE      = 3'd2;
    localparam logic [2:0] REG_INC_CAP        = 3'd3;
    localparam logic [2:0] REG_SAT_PENALTY    = 3'd4;
    localparam logic [2:0] REG_HIST_DECAY     = 3'd5;

    localparam logic [31:0] ONE_Q16 = 32'd65536;

    localparam logic [31:0] RST_PRESENT_FACTOR = 32'd65536;
    localparam logic [31:0] RST_INIT_INC       = 32'd65536;
    localparam logic [31:0] RST_INC_SCALE      = 32'd65536;
    localparam logic [31:0] RST_INC_CAP        = 32'hFFFF_FFFF;
    localparam logic [31:0] RST_SAT_PENALTY    = 32'd0;
    localparam logic [16:0] RST_HIST_DECAY     = 17'd65536;

    typedef struct packed {
        logic [2:0] func;
        logic [9:0] port;
        logic       routable;
    } t_item;

    typedef struct packed {
        logic [47:0] cost;
        logic        overuse;
    } t_result;

    typedef struct packed {
        logic        routable;
        logic [15:0] demand;
        logic [31:0] history;
    } t_entry;

endpackage

@@ hdl/routing_congestion_cost_table_core.sv @@
// Routing congestion cost table: one port-state memory plus a sequencer.
// Item flow: S_RD, S_EXEC for mark, commit, uncommit, unknown funcs, zero queries;
// a query on a routable port adds S_C1 to S_C4; a pass runs S_PRE, then per port S_SRD,
// S_SMUL, S_SWR, then S_INC, S_FIN. One item at a time; the single-port memory and its
// registered read set the pace. Reset: a clearing sweep, busy high, writes every entry.
// Results are strobed for one cycle; the receiver cannot stall them.
module routing_congestion_cost_table_core #(
    parameter int NUM_PORTS = rcct_pkg::NUM_PORTS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  rcct_pkg::t_item  i_item,
    output logic             o_strobe,
    output rcct_pkg::t_result o_result,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [2:0]       i_cfg_index,
    input  logic [31:0]      i_cfg_data
);

    localparam int AW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam logic [AW-1:0] LAST = AW'(NUM_PORTS - 1);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_EXEC  = 4'd3;
    localparam logic [3:0] S_C1    = 4'd4;
    localparam logic [3:0] S_C2    = 4'd5;
    localparam logic [3:0] S_C3    = 4'd6;
    localparam logic [3:0] S_C4    = 4'd7;
    localparam logic [3:0] S_PRE   = 4'd8;
    localparam logic [3:0] S_SRD   = 4'd9;
    localparam logic [3:0] S_SMUL  = 4'd10;
    localparam logic [3:0] S_SWR   = 4'd11;
    localparam logic [3:0] S_INC   = 4'd12;
    localparam logic [3:0] S_FIN   = 4'd13;

    // configuration registers and increment state
    logic [31:0] r_pf, r_scale, r_cap, r_sp, r_inc;
    logic [16:0] r_decay;

    logic [3:0]    r_state;
    logic [AW-1:0] r_addr;
    logic [2:0]    r_func;
    logic          r_valid;
    logic          r_new_rt;
    logic          r_strobe;
    rcct_pkg::t_result r_out;
    logic          r_over;

    rcct_pkg::t_entry r_mem [NUM_PORTS];
    rcct_pkg::t_entry r_rdata;
    rcct_pkg::t_entry r_ent;

    // arithmetic pipeline registers
    logic [32:0] r_a;
    logic [15:0] r_dem;
    logic [47:0] r_p1;
    logic [64:0] r_pl;
    logic [49:0] r_ph;
    logic [47:0] r_satinc;
    logic [48:0] r_hdec;
    logic [47:0] r_prod;
    logic [63:0] r_incp;

    logic             w_we;
    rcct_pkg::t_entry w_wdata;
    logic [48:0]      w_b;
    logic [81:0]      w_total;
    logic [31:0]      w_h1;
    logic [47:0]      w_add;
    logic [48:0]      w_sum;
    logic [47:0]      w_incv;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_strobe;
    assign o_result    = r_out;

    assign w_b     = 49'(rcct_pkg::ONE_Q16) + {1'b0, r_p1};
    assign w_total = {17'b0, r_pl} + {r_ph, 32'b0};
    assign w_incv  = r_incp[63:16];

    // sweep: decayed history plus the congestion increment, saturated
    always_comb begin
        w_h1 = (r_decay >= 17'(rcct_pkg::ONE_Q16)) ? r_ent.history : r_hdec[47:16];
        if (r_ent.routable && r_ent.demand > 16'd1) begin
            w_add = r_prod;
        end else if (r_ent.routable && r_ent.demand == 16'd1) begin
            w_add = r_satinc;
        end else begin
            w_add = 48'd0;
        end
        w_sum = {17'b0, w_h1} + {1'b0, w_add};
    end

    // memory write port
    always_comb begin
        w_we    = 1'b0;
        w_wdata = r_rdata;
        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_wdata = '0;
            end
            S_EXEC: begin
                w_wdata = r_rdata;
                unique case (r_func)
                    rcct_pkg::FUNC_MARK: begin
                        w_we             = r_valid;
                        w_wdata.routable = r_new_rt;
                    end
                    rcct_pkg::FUNC_COMMIT: begin
                        w_we = r_valid && r_rdata.routable && (r_rdata.demand != 16'hFFFF);
                        w_wdata.demand = r_rdata.demand + 16'd1;
                    end
                    rcct_pkg::FUNC_UNCOMMIT: begin
                        w_we = r_valid && r_rdata.routable && (r_rdata.demand != 16'd0);
                        w_wdata.demand = r_rdata.demand - 16'd1;
                    end
                    default: w_we = 1'b0;
                endcase
            end
            S_SWR: begin
                w_we             = 1'b1;
                w_wdata.routable = r_ent.routable;
                w_wdata.demand   = 16'd0;
                w_wdata.history  = (w_sum[48:32] != 17'd0) ? 32'hFFFF_FFFF : w_sum[31:0];
            end
            default: w_we = 1'b0;
        endcase
    end

    // port-state memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_addr] <= w_wdata;
        end
        r_rdata <= r_mem[r_addr];
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pf       <= rcct_pkg::RST_PRESENT_FACTOR;
            r_scale    <= rcct_pkg::RST_INC_SCALE;
            r_cap      <= rcct_pkg::RST_INC_CAP;
            r_sp       <= rcct_pkg::RST_SAT_PENALTY;
            r_decay    <= rcct_pkg::RST_HIST_DECAY;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rcct_pkg::REG_PRESENT_FACTOR: r_pf       <= i_cfg_data;
                // only reloads the running increment, done in the sequencer
                rcct_pkg::REG_INIT_INC:       ;
                rcct_pkg::REG_INC_SCALE:      r_scale    <= i_cfg_data;
                rcct_pkg::REG_INC_CAP:        r_cap      <= i_cfg_data;
                rcct_pkg::REG_SAT_PENALTY:    r_sp       <= i_cfg_data;
                rcct_pkg::REG_HIST_DECAY:     r_decay    <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_p1     <= {32'b0, r_dem} * {16'b0, r_pf};
        r_pl     <= {32'b0, r_a} * {33'b0, w_b[31:0]};
        r_ph     <= {17'b0, r_a} * {33'b0, w_b[48:32]};
        r_satinc <= 48'(({32'b0, r_inc} * {32'b0, r_sp}) >> 16);
        r_hdec   <= {17'b0, r_rdata.history} * {32'b0, r_decay};
        r_prod   <= {16'b0, r_inc} * {32'b0, r_rdata.demand - 16'd1};
        r_incp   <= {32'b0, r_inc} * {32'b0, r_scale};
        r_ent    <= r_rdata;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_addr   <= '0;
            r_strobe <= 1'b0;
            r_out    <= '0;
            r_inc    <= rcct_pkg::RST_INIT_INC;
            r_over   <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_valid && i_cfg_index == rcct_pkg::REG_INIT_INC) begin
                r_inc <= i_cfg_data;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_addr == LAST) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_func   <= i_item.func;
                        r_new_rt <= i_item.routable;
                        r_valid  <= ({22'b0, i_item.port} < 32'(NUM_PORTS));
                        r_addr   <= AW'(i_item.port);
                        r_state  <= (i_item.func == rcct_pkg::FUNC_PASS) ? S_PRE : S_RD;
                    end
                end
                S_RD: r_state <= S_EXEC;
                S_EXEC: begin
                    if (r_func == rcct_pkg::FUNC_QUERY && r_valid && r_rdata.routable) begin
                        r_a     <= 33'(rcct_pkg::ONE_Q16) + {1'b0, r_rdata.history};
                        r_dem   <= r_rdata.demand;
                        r_state <= S_C1;
                    end else begin
                        r_out    <= '0;
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_C1: r_state <= S_C2;
                S_C2: r_state <= S_C3;
                S_C3: r_state <= S_C4;
                S_C4: begin
                    r_out.cost    <= (w_total[81:64] != 18'd0) ? {48{1'b1}} : w_total[63:16];
                    r_out.overuse <= 1'b0;
                    r_strobe      <= 1'b1;
                    r_state       <= S_IDLE;
                end
                S_PRE: begin
                    r_over  <= 1'b0;
                    r_addr  <= '0;
                    r_state <= S_SRD;
                end
                S_SRD: r_state <= S_SMUL;
                S_SMUL: r_state <= S_SWR;
                S_SWR: begin
                    if (r_ent.routable && r_ent.demand > 16'd1) begin
                        r_over <= 1'b1;
                    end
                    if (r_addr == LAST) begin
                        r_state <= S_INC;
                    end else begin
                        r_addr  <= r_addr + 1'b1;
                        r_state <= S_SRD;
                    end
                end
                S_INC: r_state <= S_FIN;
                S_FIN: begin
                    r_inc         <= (w_incv < {16'b0, r_cap}) ? w_incv[31:0] : r_cap;
                    r_out.cost    <= 48'd0;
                    r_out.overuse <= r_over;
                    r_strobe      <= 1'b1;
                    r_state       <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // a result beat only ends work that was under way
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy)) else $error("result without work");

    // an accepted item makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("item accepted but not busy");

    // an overuse beat carries no cost
    a_over_no_cost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.overuse) |-> (o_result.cost == 48'd0))
        else $error("overuse beat with cost");

    // no memory write while idle
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_we) else $error("memory write while idle");

endmodule

@@ verif/rcct_checker.sv @@
// Checker for the routing congestion cost table: watches item, result and config beats.
// Keeps its own port table, predicts each result and compares it field by field.
// Depends on rcct_pkg for the beat types and the function and register codes.
module rcct_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  rcct_pkg::t_item    i_item,
    input  logic               i_strobe,
    input  rcct_pkg::t_result  i_result,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int PORTS = rcct_pkg::NUM_PORTS_DEF;
    localparam logic [47:0] COST_MAX = 48'hFFFF_FFFF_FFFF;

    // Shadow configuration
    logic [31:0] pres_factor, init_inc, inc_scale, inc_cap, sat_penalty;
    logic [16:0] hist_decay;

    // Shadow port table
    logic        port_routable [PORTS];
    logic [15:0] port_demand   [PORTS];
    logic [31:0] port_history  [PORTS];
    logic [31:0] cur_inc;

    rcct_pkg::t_result cost_queue[$];
    int      fails;

    assign o_fail_count = fails;
    assign o_pending    = cost_queue.size();

    initial fails = 0;

    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        fails++;
    endtask

    function automatic logic [31:0] add_sat32(input logic [31:0] h, input logic [63:0] add);
        logic [64:0] s;
        s = {33'd0, h} + {1'b0, add};
        return (s > 65'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [47:0] port_cost_of(input logic [9:0] p);
        logic [95:0] a, b, prod;
        if (p >= PORTS || !port_routable[p]) return '0;
        a = 96'd65536 + port_history[p];
        b = 96'd65536 + port_demand[p] * pres_factor;
        prod = a * b;
        if (prod[95:64] != 0) return COST_MAX;
        return prod[63:16];
    endfunction

    // Sweep every port: decay, overuse or saturation charge, clear demand, scale increment
    function automatic logic sweep_pass();
        logic        over;
        logic [63:0] inc;
        logic [15:0] d;
        over = 1'b0;
        for (int i = 0; i < PORTS; i++) begin
            d = port_demand[i];
            if (hist_decay < 17'd65536)
                port_history[i] = 32'((64'(port_history[i]) * hist_decay) >> 16);
            if (port_routable[i] && d > 1) begin
                over = 1'b1;
                port_history[i] = add_sat32(port_history[i], 64'(cur_inc) * (d - 16'd1));
            end else if (port_routable[i] && d == 1) begin
                port_history[i] = add_sat32(port_history[i],
                                            (64'(cur_inc) * sat_penalty) >> 16);
            end
            port_demand[i] = '0;
        end
        inc = (64'(cur_inc) * inc_scale) >> 16;
        cur_inc = (inc < inc_cap) ? inc[31:0] : inc_cap;
        return over;
    endfunction

    function automatic rcct_pkg::t_result predict_item(input rcct_pkg::t_item it);
        rcct_pkg::t_result r;
        logic    ok;
        r  = '0;
        ok = it.port < PORTS;
        case (it.func)
            rcct_pkg::FUNC_MARK: if (ok) port_routable[it.port] = it.routable;
            rcct_pkg::FUNC_COMMIT:
                if (ok && port_routable[it.port] && port_demand[it.port] != 16'hFFFF)
                    port_demand[it.port]++;
            rcct_pkg::FUNC_UNCOMMIT:
                if (ok && port_routable[it.port] && port_demand[it.port] != 0)
                    port_demand[it.port]--;
            rcct_pkg::FUNC_QUERY: r.cost = port_cost_of(it.port);
            rcct_pkg::FUNC_PASS:  r.overuse = sweep_pass();
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        rcct_pkg::t_result want;
        rcct_pkg::t_result predicted;
        if (!i_rst_n) begin
            pres_factor = rcct_pkg::RST_PRESENT_FACTOR;
            init_inc    = rcct_pkg::RST_INIT_INC;
            inc_scale   = rcct_pkg::RST_INC_SCALE;
            inc_cap     = rcct_pkg::RST_INC_CAP;
            sat_penalty = rcct_pkg::RST_SAT_PENALTY;
            hist_decay  = rcct_pkg::RST_HIST_DECAY;
            cur_inc     = rcct_pkg::RST_INIT_INC;
            for (int i = 0; i < PORTS; i++) begin
                port_routable[i] = 1'b0;
                port_demand[i]   = '0;
                port_history[i]  = '0;
            end
            cost_queue.delete();
        end else begin
            // Compare result beat with the oldest expectation
            if (i_strobe) begin
                if (cost_queue.size() == 0) begin
                    report_mismatch("unexpected result", i_result.cost, '0);
                end else begin
                    want = cost_queue.pop_front();
                    if (i_result.cost !== want.cost)
                        report_mismatch("cost", i_result.cost, want.cost);
                    if (i_result.overuse !== want.overuse)
                        report_mismatch("overuse", 48'(i_result.overuse), 48'(want.overuse));
                end
            end
            // Apply config beat
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    rcct_pkg::REG_PRESENT_FACTOR: pres_factor = i_cfg_data;
                    rcct_pkg::REG_INIT_INC: begin
                        init_inc = i_cfg_data;
                        cur_inc  = i_cfg_data;
                    end
                    rcct_pkg::REG_INC_SCALE:   inc_scale   = i_cfg_data;
                    rcct_pkg::REG_INC_CAP:     inc_cap     = i_cfg_data;
                    rcct_pkg::REG_SAT_PENALTY: sat_penalty = i_cfg_data;
                    rcct_pkg::REG_HIST_DECAY:  hist_decay  = i_cfg_data[16:0];
                    default: ;
                endcase
            end
            // Predict accepted item beat and append it to the expectations
            if (i_start && !i_busy) begin
                predicted  = predict_item(i_item);
                cost_queue = {cost_queue, predicted};
            end
        end
    end
endmodule

@@ verif/tb_routing_congestion_cost_table_core.sv @@
// Testbench top for routing_congestion_cost_table_core: clock, reset, stimulus, verdict.
// Drives directed then random item beats across several config settings.
// Depends on rcct_pkg, the core and rcct_checker.
module tb_routing_congestion_cost_table_core;

    localparam int CYCLE_LIMIT = 20_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    rcct_pkg::t_item   i_item;
    logic        o_strobe;
    rcct_pkg::t_result o_result;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    int          fail_count;
    int          pending;
    int          cycles;

    routing_congestion_cost_table_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_item(i_item),
        .o_strobe(o_strobe), .o_result(o_result), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    rcct_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy), .i_item(i_item),
        .i_strobe(o_strobe), .i_result(o_result), .i_cfg_valid(i_cfg_valid),
        .i_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Stop a hung run
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Send one item beat, then idle for a random gap
    task automatic send_item(input logic [2:0] f, input logic [9:0] p, input logic r);
        int gap;
        start  <= 1'b1;
        i_item <= '{func: f, port: p, routable: r};
        do @(posedge i_clk); while (busy);
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Write one register once all results are back
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(32768, 196608);
            default: return $urandom();
        endcase
    endfunction

    task automatic random_items(input int count);
        logic [2:0] f;
        logic [9:0] p;
        int         roll;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 10)      f = rcct_pkg::FUNC_MARK;
            else if (roll < 48) f = rcct_pkg::FUNC_COMMIT;
            else if (roll < 62) f = rcct_pkg::FUNC_UNCOMMIT;
            else if (roll < 90) f = rcct_pkg::FUNC_QUERY;
            else if (roll < 96) f = rcct_pkg::FUNC_PASS;
            else                f = 3'($urandom_range(5, 7));
            // Focus on a few ports so demand builds up
            if ($urandom_range(0, 9) < 8) p = 10'($urandom_range(0, 7));
            else                          p = 10'($urandom());
            send_item(f, p, ($urandom_range(0, 4) != 0));
        end
    endtask

    initial begin
        start       <= 1'b0;
        i_item      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= rcct_pkg::REG_PRESENT_FACTOR;
        i_cfg_data  <= '0;
        i_rst_n     <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset config, edge ports, demand limits, unknown funcs
        send_item(rcct_pkg::FUNC_QUERY, 10'd0, 1'b0);
        send_item(rcct_pkg::FUNC_COMMIT, 10'd1023, 1'b0);
        send_item(rcct_pkg::FUNC_MARK, 10'd0, 1'b1);
        send_item(rcct_pkg::FUNC_MARK, 10'd1023, 1'b1);
        send_item(rcct_pkg::FUNC_UNCOMMIT, 10'd0, 1'b0);
        send_item(rcct_pkg::FUNC_COMMIT, 10'd0, 1'b0);
        send_item(rcct_pkg::FUNC_COMMIT, 10'd0, 1'b0);
        send_item(rcct_pkg::FUNC_COMMIT, 10'd0, 1'b0);
        send_item(rcct_pkg::FUNC_COMMIT, 10'd1023, 1'b0);
        send_item(rcct_pkg::FUNC_QUERY, 10'd0, 1'b0);
        send_item(rcct_pkg::FUNC_QUERY, 10'd1023, 1'b1);
        send_item(rcct_pkg::FUNC_MARK, 10'd0, 1'b0);
        send_item(rcct_pkg::FUNC_QUERY, 10'd0, 1'b0);
        send_item(rcct_pkg::FUNC_MARK, 10'd0, 1'b1);
        send_item(rcct_pkg::FUNC_PASS, 10'd0, 1'b0);
        send_item(rcct_pkg::FUNC_QUERY, 10'd0, 1'b0);
        send_item(rcct_pkg::FUNC_QUERY, 10'd1023, 1'b0);
        send_item(3'd5, 10'd682, 1'b1);
        send_item(3'd6, 10'd341, 1'b0);
        send_item(3'd7, 10'd1023, 1'b1);
        send_item(rcct_pkg::FUNC_PASS, 10'd0, 1'b0);

        random_items(150);

        // Extreme settings, then random settings
        write_reg(rcct_pkg::REG_PRESENT_FACTOR, 32'hFFFF_FFFF);
        write_reg(rcct_pkg::REG_INIT_INC, 32'hFFFF_FFFF);
        write_reg(rcct_pkg::REG_SAT_PENALTY, 32'hFFFF_FFFF);
        write_reg(rcct_pkg::REG_HIST_DECAY, 32'd0);
        random_items(150);

        write_reg(rcct_pkg::REG_PRESENT_FACTOR, 32'd0);
        write_reg(rcct_pkg::REG_INIT_INC, 32'd0);
        write_reg(rcct_pkg::REG_INC_SCALE, 32'd0);
        write_reg(rcct_pkg::REG_INC_CAP, 32'd0);
        write_reg(rcct_pkg::REG_SAT_PENALTY, 32'd0);
        write_reg(rcct_pkg::REG_HIST_DECAY, 32'd65536);
        random_items(150);

        write_reg(rcct_pkg::REG_INIT_INC, 32'd65536);
        write_reg(rcct_pkg::REG_INC_SCALE, 32'hFFFF_FFFF);
        write_reg(rcct_pkg::REG_INC_CAP, 32'hFFFF_FFFF);
        write_reg(rcct_pkg::REG_HIST_DECAY, 32'd32768);
        random_items(150);

        for (int ph = 0; ph < 2; ph++) begin
            write_reg(rcct_pkg::REG_PRESENT_FACTOR, pick_word());
            write_reg(rcct_pkg::REG_INIT_INC, pick_word());
            write_reg(rcct_pkg::REG_INC_SCALE, pick_word());
            write_reg(rcct_pkg::REG_INC_CAP, pick_word());
            write_reg(rcct_pkg::REG_SAT_PENALTY, pick_word());
            write_reg(rcct_pkg::REG_HIST_DECAY, 32'($urandom_range(0, 65536)));
            random_items(150);
        end

        // Drain
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

@@ routing_congestion_cost_table_core.f @@
hdl/rcct_pkg.sv
hdl/routing_congestion_cost_table_core.sv
verif/rcct_checker.sv
verif/tb_routing_congestion_cost_table_core.sv
